[rtl/nvme_chunked_io_queue_issuer_assert.svh]
// Assertion macros for the checker file of the queue issuer.
// No dependencies; included by bare file name.
`ifndef NVME_CHUNKED_IO_QUEUE_ISSUER_ASSERT_SVH
`define NVME_CHUNKED_IO_QUEUE_ISSUER_ASSERT_SVH

// same-cycle implication
`define NCI_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NCI_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/nci_pkg.sv]
// Package for the NVMe chunked I/O queue issuer: codes, defaults, item and result types.
// No dependencies.
package nci_pkg;

  localparam int DEFAULT_QUEUE_DEPTH   = 32;
  localparam int DEFAULT_CHUNK_SECTORS = 8;

  localparam int SECTOR_SHIFT  = 9;
  localparam int CQE_PHASE_BIT = 16;
  localparam int CQE_SC_LSB    = 17;
  localparam int CQE_SC_MSB    = 27;

  localparam logic OP_REQUEST    = 1'b0;
  localparam logic OP_COMPLETION = 1'b1;

  localparam logic [1:0] KIND_ISSUE  = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_FAIL   = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  localparam logic [1:0] OPC_NONE  = 2'd0;
  localparam logic [1:0] OPC_WRITE = 2'd1;
  localparam logic [1:0] OPC_READ  = 2'd2;

  localparam logic REG_NAMESPACE_SECTORS = 1'b0;
  localparam logic REG_DEVICE_PRESENT    = 1'b1;

  typedef struct packed {
    logic        op;
    logic [63:0] start_sector;
    logic [31:0] byte_count;
    logic        is_write;
    logic [31:0] cqe_status_word;
  } nci_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  opcode;
    logic [15:0] command_id;
    logic [4:0]  sq_slot;
    logic [4:0]  sq_doorbell;
    logic [63:0] start_lba;
    logic [2:0]  blocks_minus_one;
    logic        cq_doorbell_valid;
    logic [4:0]  cq_doorbell;
    logic [10:0] status_code;
  } nci_result_t;

endpackage

[rtl/nvme_chunked_io_queue_issuer.sv]
// Host side of one NVMe I/O queue pair: checks transfer requests, splits them into
// chunks and issues one command at a time, consuming completions by phase. Accepts one
// transaction per clock while the output side does not stall; each result passes through
// the input register, then the result register, before it reaches the output ports. The
// queue pair state is updated by the step logic between the two registers, so back-to-back
// transactions see each other's effect. No clearing pass after reset. Depends on nci_pkg
// and nci_engine.
module nvme_chunked_io_queue_issuer import nci_pkg::*; #(
  parameter int QUEUE_DEPTH   = DEFAULT_QUEUE_DEPTH,
  parameter int CHUNK_SECTORS = DEFAULT_CHUNK_SECTORS
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [63:0] start_sector,
  input  logic [31:0] byte_count,
  input  logic        is_write,
  input  logic [31:0] cqe_status_word,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [1:0]  opcode,
  output logic [15:0] command_id,
  output logic [4:0]  sq_slot,
  output logic [4:0]  sq_doorbell,
  output logic [63:0] start_lba,
  output logic [2:0]  blocks_minus_one,
  output logic        cq_doorbell_valid,
  output logic [4:0]  cq_doorbell,
  output logic [10:0] status_code
);

  logic [63:0] namespace_sectors;
  logic        device_present;

  logic        s1_valid;
  nci_item_t   s1_item;
  nci_result_t out_res;

  logic        out_free;
  logic        fire;
  logic        accept;
  nci_result_t step_res;
  logic        step_has_result;

  assign out_free = !out_valid || !out_stall;
  assign fire     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      namespace_sectors <= '0;
      device_present    <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NAMESPACE_SECTORS: namespace_sectors <= cfg_data;
        REG_DEVICE_PRESENT:    device_present    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_item.op              <= op;
      s1_item.start_sector    <= start_sector;
      s1_item.byte_count      <= byte_count;
      s1_item.is_write        <= is_write;
      s1_item.cqe_status_word <= cqe_status_word;
    end
  end

  nci_engine #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .CHUNK_SECTORS (CHUNK_SECTORS)
  ) u_engine (
    .clk               (clk),
    .rst               (rst),
    .fire              (fire),
    .item              (s1_item),
    .namespace_sectors (namespace_sectors),
    .device_present    (device_present),
    .res               (step_res),
    .has_result        (step_has_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire && step_has_result;
    end
    if (fire && step_has_result) begin
      out_res <= step_res;
    end
  end

  assign kind              = out_res.kind;
  assign opcode            = out_res.opcode;
  assign command_id        = out_res.command_id;
  assign sq_slot           = out_res.sq_slot;
  assign sq_doorbell       = out_res.sq_doorbell;
  assign start_lba         = out_res.start_lba;
  assign blocks_minus_one  = out_res.blocks_minus_one;
  assign cq_doorbell_valid = out_res.cq_doorbell_valid;
  assign cq_doorbell       = out_res.cq_doorbell;
  assign status_code       = out_res.status_code;

endmodule

[rtl/nci_engine.sv]
// Queue pair state and per-transaction step logic: request check, chunking, completion intake.
// Depends on nci_pkg.
module nci_engine import nci_pkg::*; #(
  parameter int QUEUE_DEPTH   = DEFAULT_QUEUE_DEPTH,
  parameter int CHUNK_SECTORS = DEFAULT_CHUNK_SECTORS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  nci_item_t   item,
  input  logic [63:0] namespace_sectors,
  input  logic        device_present,
  output nci_result_t res,
  output logic        has_result
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(CHUNK_SECTORS + 1);
  localparam int SW = 32 - SECTOR_SHIFT;

  logic [15:0]   next_command_id, next_command_id_next;
  logic [QW-1:0] sq_tail, sq_tail_next;
  logic [QW-1:0] cq_head, cq_head_next;
  logic          expected_phase, expected_phase_next;
  logic          busy, busy_next;
  logic          write_mode, write_mode_next;
  logic [63:0]   next_lba, next_lba_next;
  logic [SW-1:0] sectors_left, sectors_left_next;
  logic [CW-1:0] chunk_blocks, chunk_blocks_next;

  logic [SW-1:0] req_sectors;
  logic [63:0]   req_sectors_wide;
  logic          req_bad;
  logic          cqe_new;
  logic [10:0]   code;
  logic [QW-1:0] head_inc, tail_inc;
  logic [63:0]   lba_adv;
  logic [SW-1:0] sl_adv;
  logic          last_chunk;
  logic          do_issue;
  logic [SW-1:0] iss_sectors;
  logic [63:0]   iss_lba;
  logic          iss_write;
  logic [CW-1:0] iss_blocks;

  assign req_sectors      = item.byte_count[31:SECTOR_SHIFT];
  assign req_sectors_wide = 64'(req_sectors);
  assign req_bad = busy || !device_present || (item.byte_count == '0)
                || (item.byte_count[SECTOR_SHIFT-1:0] != '0)
                || (req_sectors_wide > namespace_sectors)
                || (item.start_sector > namespace_sectors - req_sectors_wide);

  assign cqe_new  = busy && (item.cqe_status_word[CQE_PHASE_BIT] == expected_phase);
  assign code     = item.cqe_status_word[CQE_SC_MSB:CQE_SC_LSB];
  assign head_inc = (cq_head == QW'(QUEUE_DEPTH - 1)) ? '0 : cq_head + QW'(1);
  assign tail_inc = (sq_tail == QW'(QUEUE_DEPTH - 1)) ? '0 : sq_tail + QW'(1);

  assign lba_adv    = next_lba + 64'(chunk_blocks);
  assign sl_adv     = sectors_left - SW'(chunk_blocks);
  assign last_chunk = (sl_adv == '0) || (chunk_blocks == '0);

  assign iss_sectors = (item.op == OP_REQUEST) ? req_sectors : sl_adv;
  assign iss_lba     = (item.op == OP_REQUEST) ? item.start_sector : lba_adv;
  assign iss_write   = (item.op == OP_REQUEST) ? item.is_write : write_mode;
  assign iss_blocks  = (iss_sectors > SW'(CHUNK_SECTORS)) ? CW'(CHUNK_SECTORS)
                                                          : iss_sectors[CW-1:0];

  always_comb begin
    res                  = '0;
    has_result           = 1'b0;
    do_issue             = 1'b0;
    next_command_id_next = next_command_id;
    sq_tail_next         = sq_tail;
    cq_head_next         = cq_head;
    expected_phase_next  = expected_phase;
    busy_next            = busy;
    write_mode_next      = write_mode;
    next_lba_next        = next_lba;
    sectors_left_next    = sectors_left;
    chunk_blocks_next    = chunk_blocks;

    unique case (item.op)
      OP_REQUEST: begin
        has_result = 1'b1;
        if (req_bad) begin
          res.kind = KIND_REJECT;
        end else begin
          busy_next       = 1'b1;
          write_mode_next = item.is_write;
          do_issue        = 1'b1;
        end
      end
      OP_COMPLETION: begin
        if (cqe_new) begin
          has_result            = 1'b1;
          cq_head_next          = head_inc;
          if (head_inc == '0) begin
            expected_phase_next = ~expected_phase;
          end
          res.cq_doorbell_valid = 1'b1;
          res.cq_doorbell       = 5'(head_inc);
          res.status_code       = code;
          if (code != '0) begin
            busy_next = 1'b0;
            res.kind  = KIND_FAIL;
          end else if (last_chunk) begin
            busy_next         = 1'b0;
            next_lba_next     = lba_adv;
            sectors_left_next = '0;
            res.kind          = KIND_DONE;
          end else begin
            do_issue = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (do_issue) begin
      res.kind             = KIND_ISSUE;
      res.opcode           = iss_write ? OPC_WRITE : OPC_READ;
      res.command_id       = next_command_id;
      res.sq_slot          = 5'(sq_tail);
      res.sq_doorbell      = 5'(tail_inc);
      res.start_lba        = iss_lba;
      res.blocks_minus_one = 3'(iss_blocks - CW'(1));
      next_lba_next        = iss_lba;
      sectors_left_next    = iss_sectors;
      chunk_blocks_next    = iss_blocks;
      sq_tail_next         = tail_inc;
      next_command_id_next = next_command_id + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_command_id <= 16'd1;
      sq_tail         <= '0;
      cq_head         <= '0;
      expected_phase  <= 1'b1;
      busy            <= 1'b0;
      write_mode      <= 1'b0;
      next_lba        <= '0;
      sectors_left    <= '0;
      chunk_blocks    <= '0;
    end else if (fire) begin
      next_command_id <= next_command_id_next;
      sq_tail         <= sq_tail_next;
      cq_head         <= cq_head_next;
      expected_phase  <= expected_phase_next;
      busy            <= busy_next;
      write_mode      <= write_mode_next;
      next_lba        <= next_lba_next;
      sectors_left    <= sectors_left_next;
      chunk_blocks    <= chunk_blocks_next;
    end
  end

endmodule

[rtl/nci_checker.sv]
// Port-level checker for the queue issuer, bound to the top level.
// Depends on nci_pkg and nvme_chunked_io_queue_issuer_assert.svh.
`include "nvme_chunked_io_queue_issuer_assert.svh"

module nci_checker import nci_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  kind,
  input logic [1:0]  opcode,
  input logic [15:0] command_id,
  input logic [2:0]  blocks_minus_one,
  input logic        cq_doorbell_valid,
  input logic [4:0]  cq_doorbell,
  input logic [10:0] status_code
);

  `NCI_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(kind) && $stable(command_id) && $stable(status_code), "stalled result changed")

  `NCI_ASSERT_IMPL(a_no_issue_fields, clk, rst, out_valid && kind != KIND_ISSUE, opcode == OPC_NONE && command_id == 16'd0 && blocks_minus_one == 3'd0, "command fields set on non-issue result")

  `NCI_ASSERT_IMPL(a_reject_clean, clk, rst, out_valid && kind == KIND_REJECT, !cq_doorbell_valid && cq_doorbell == 5'd0 && status_code == 11'd0, "rejected request carries completion fields")

  `NCI_ASSERT_IMPL(a_fail_status, clk, rst, out_valid && kind == KIND_FAIL, cq_doorbell_valid && status_code != 11'd0, "failed transfer without error completion")

endmodule

bind nvme_chunked_io_queue_issuer nci_checker u_nci_checker (.*);

[dv/testbench.sv]
`timescale 1ns / 100ps
// Testbench for nvme_chunked_io_queue_issuer: directed and random requests and completions,
// each result checked against a queue-pair tracker. Depends on nci_pkg and the RTL only.
import nci_pkg::*;

class queue_pair_tracker;
  logic [63:0] ns_sectors;
  logic        present;
  logic [15:0] next_cid;
  int unsigned sq_tail;
  int unsigned cq_head;
  logic        phase;
  logic        busy;
  logic        write_mode;
  logic [63:0] next_lba;
  logic [31:0] bytes_left;
  logic [3:0]  chunk_blocks;
  nci_result_t due_results[$];
  int          mismatches;

  function new();
    ns_sectors   = '0;
    present      = 1'b0;
    next_cid     = 16'd1;
    sq_tail      = 0;
    cq_head      = 0;
    phase        = 1'b1;
    busy         = 1'b0;
    write_mode   = 1'b0;
    next_lba     = '0;
    bytes_left   = '0;
    chunk_blocks = '0;
    mismatches   = 0;
  endfunction

  function void set_config(logic [63:0] ns, logic dev);
    ns_sectors = ns;
    present    = dev;
  endfunction

  function nci_result_t issue_chunk(nci_result_t r);
    logic [31:0] left_sectors;
    left_sectors = bytes_left >> SECTOR_SHIFT;
    chunk_blocks = (left_sectors > DEFAULT_CHUNK_SECTORS) ? 4'(DEFAULT_CHUNK_SECTORS)
                                                          : 4'(left_sectors);
    r.kind             = KIND_ISSUE;
    r.opcode           = write_mode ? OPC_WRITE : OPC_READ;
    r.command_id       = next_cid;
    r.sq_slot          = 5'(sq_tail);
    sq_tail            = (sq_tail + 1) % DEFAULT_QUEUE_DEPTH;
    r.sq_doorbell      = 5'(sq_tail);
    r.start_lba        = next_lba;
    r.blocks_minus_one = 3'(chunk_blocks - 4'd1);
    next_cid           = next_cid + 16'd1;
    return r;
  endfunction

  function void note_transaction(nci_item_t it);
    nci_result_t r;
    logic [63:0] sectors;
    logic [10:0] code;
    r = '0;
    if (it.op == OP_REQUEST) begin
      sectors = 64'(it.byte_count >> SECTOR_SHIFT);
      if (busy || !present || it.byte_count == '0 || it.byte_count[SECTOR_SHIFT-1:0] != '0 ||
          sectors > ns_sectors || it.start_sector > ns_sectors - sectors) begin
        r.kind = KIND_REJECT;
      end else begin
        busy       = 1'b1;
        write_mode = it.is_write;
        next_lba   = it.start_sector;
        bytes_left = it.byte_count;
        r = issue_chunk(r);
      end
      due_results.push_back(r);
      return;
    end
    // idle or stale entry: nothing consumed
    if (!busy || it.cqe_status_word[CQE_PHASE_BIT] != phase) return;
    code    = it.cqe_status_word[CQE_SC_MSB:CQE_SC_LSB];
    cq_head = (cq_head + 1) % DEFAULT_QUEUE_DEPTH;
    if (cq_head == 0) phase = ~phase;
    r.cq_doorbell_valid = 1'b1;
    r.cq_doorbell       = 5'(cq_head);
    r.status_code       = code;
    if (code != '0) begin
      busy   = 1'b0;
      r.kind = KIND_FAIL;
    end else begin
      next_lba   = next_lba + 64'(chunk_blocks);
      bytes_left = bytes_left - {chunk_blocks, 9'b0};
      if (bytes_left == '0 || chunk_blocks == '0) begin
        busy       = 1'b0;
        bytes_left = '0;
        r.kind     = KIND_DONE;
      end else begin
        r = issue_chunk(r);
      end
    end
    due_results.push_back(r);
  endfunction

  task flag_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task compare_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task check_outcome(nci_result_t got);
    nci_result_t want;
    if (due_results.size() == 0) begin
      flag_mismatch("result with no transaction pending");
      return;
    end
    want = due_results.pop_front();
    compare_field("kind", got.kind, want.kind);
    compare_field("opcode", got.opcode, want.opcode);
    compare_field("command_id", got.command_id, want.command_id);
    compare_field("sq_slot", got.sq_slot, want.sq_slot);
    compare_field("sq_doorbell", got.sq_doorbell, want.sq_doorbell);
    compare_field("start_lba", got.start_lba, want.start_lba);
    compare_field("blocks_minus_one", got.blocks_minus_one, want.blocks_minus_one);
    compare_field("cq_doorbell_valid", got.cq_doorbell_valid, want.cq_doorbell_valid);
    compare_field("cq_doorbell", got.cq_doorbell, want.cq_doorbell);
    compare_field("status_code", got.status_code, want.status_code);
  endtask
endclass

module testbench;
  localparam int STALL_LIMIT = 1000;
  localparam int WRAP_CHUNKS = 40;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        op;
  logic [63:0] start_sector;
  logic [31:0] byte_count;
  logic        is_write;
  logic [31:0] cqe_status_word;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [1:0]  opcode;
  logic [15:0] command_id;
  logic [4:0]  sq_slot;
  logic [4:0]  sq_doorbell;
  logic [63:0] start_lba;
  logic [2:0]  blocks_minus_one;
  logic        cq_doorbell_valid;
  logic [4:0]  cq_doorbell;
  logic [10:0] status_code;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int idle_cycles   = 0;

  queue_pair_tracker tracker = new();

  nvme_chunked_io_queue_issuer dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .op, .start_sector, .byte_count, .is_write, .cqe_status_word,
    .out_valid, .out_stall, .kind, .opcode, .command_id, .sq_slot, .sq_doorbell,
    .start_lba, .blocks_minus_one, .cq_doorbell_valid, .cq_doorbell, .status_code
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tracker.check_outcome({kind, opcode, command_id, sq_slot, sq_doorbell, start_lba,
                             blocks_minus_one, cq_doorbell_valid, cq_doorbell, status_code});
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("[nvme_chunked_io_queue_issuer] ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic nci_item_t request(logic [63:0] st, logic [31:0] cnt, logic wr);
    nci_item_t it;
    it.op              = OP_REQUEST;
    it.start_sector    = st;
    it.byte_count      = cnt;
    it.is_write        = wr;
    it.cqe_status_word = $urandom;
    return it;
  endfunction

  function automatic nci_item_t completion(logic ph, logic [10:0] code);
    nci_item_t it;
    it.op              = OP_COMPLETION;
    it.start_sector    = rand64();
    it.byte_count      = $urandom;
    it.is_write        = $urandom_range(1);
    it.cqe_status_word = $urandom;
    it.cqe_status_word[CQE_PHASE_BIT] = ph;
    it.cqe_status_word[CQE_SC_MSB:CQE_SC_LSB] = code;
    return it;
  endfunction

  function automatic nci_item_t random_request();
    logic [63:0] ns;
    logic [63:0] span;
    logic [63:0] st;
    logic [31:0] sectors;
    logic [31:0] cnt;
    int pick;
    ns      = tracker.ns_sectors;
    pick    = $urandom_range(99);
    sectors = ($urandom_range(19) == 0) ? $urandom_range(8388607, 1) : $urandom_range(40, 1);
    cnt     = sectors << SECTOR_SHIFT;
    if (pick < 70) begin
      if (ns >= 64'(sectors)) begin
        span = ns - 64'(sectors);
        if ($urandom_range(7) == 0) st = span;
        else st = (span == '1) ? rand64() : rand64() % (span + 64'd1);
      end else begin
        st = rand64();
      end
    end else if (pick < 80) begin
      cnt = ($urandom_range(3) == 0) ? '0 : $urandom;
      if (cnt != '0 && cnt[SECTOR_SHIFT-1:0] == '0) cnt[0] = 1'b1;
      st = 64'($urandom_range(16));
    end else if (pick < 90) begin
      // one sector past the namespace end
      st = (ns >= 64'(sectors)) ? ns - 64'(sectors) + 64'd1 : '1;
    end else begin
      st  = rand64();
      cnt = $urandom;
    end
    return request(st, cnt, $urandom_range(1));
  endfunction

  function automatic nci_item_t random_completion();
    int pick;
    pick = $urandom_range(99);
    if (pick < 12) return completion(~tracker.phase, 11'($urandom));
    if (pick < 20) return completion(tracker.phase, 11'($urandom_range(2047, 1)));
    return completion(tracker.phase, '0);
  endfunction

  function automatic nci_item_t random_item();
    if (tracker.busy)
      return ($urandom_range(99) < 85) ? random_completion() : random_request();
    return ($urandom_range(99) < 85) ? random_request() : random_completion();
  endfunction

  task automatic send_item(nci_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    op              <= it.op;
    start_sector    <= it.start_sector;
    byte_count      <= it.byte_count;
    is_write        <= it.is_write;
    cqe_status_word <= it.cqe_status_word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_transaction(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [63:0] ns, logic dev);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= REG_NAMESPACE_SECTORS;
    cfg_data  <= ns;
    @(posedge clk);
    cfg_index <= REG_DEVICE_PRESENT;
    cfg_data  <= {63'b0, dev};
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.set_config(ns, dev);
  endtask

  task automatic run_random(int count, int idle_pct, int stall);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (count) send_item(random_item());
  endtask

  initial begin
    nci_item_t it;
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = REG_NAMESPACE_SECTORS;
    cfg_data        = '0;
    in_valid        = 1'b0;
    op              = OP_REQUEST;
    start_sector    = '0;
    byte_count      = '0;
    is_write        = 1'b0;
    cqe_status_word = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // device absent, then a completion with nothing in flight
    send_item(request(64'd0, 32'd512, 1'b0));
    send_item(completion(tracker.phase, '0));

    configure(64'd100, 1'b1);
    send_item(request(64'd0, 32'd0, 1'b1));
    send_item(request(64'd0, 32'd513, 1'b1));
    send_item(request(64'd95, 32'd6 << SECTOR_SHIFT, 1'b0));
    send_item(request(64'd90, 32'd10 << SECTOR_SHIFT, 1'b1));
    send_item(request(64'd0, 32'd512, 1'b0));
    send_item(completion(~tracker.phase, '0));
    send_item(completion(tracker.phase, '0));
    send_item(completion(tracker.phase, '0));
    send_item(request(64'd0, 32'd512, 1'b0));
    send_item(completion(tracker.phase, 11'h7ff));

    configure('1, 1'b1);
    send_item(request('1, 32'd512, 1'b1));
    send_item(request(64'hffff_ffff_ffff_fffe, 32'd512, 1'b1));
    send_item(completion(tracker.phase, 11'h001));
    send_item(request(64'd0, 32'hffff_fe00, 1'b0));
    it = completion(tracker.phase, 11'h7ff);
    it.cqe_status_word = '1;
    it.cqe_status_word[CQE_PHASE_BIT] = tracker.phase;
    send_item(it);

    configure(64'd0, 1'b1);
    send_item(request(64'd0, 32'd512, 1'b1));

    // long transfer: rings wrap and the phase flips
    configure('1, 1'b1);
    send_item(request(rand64() >> 1, 32'(WRAP_CHUNKS) * 32'd4096, 1'b1));
    repeat (WRAP_CHUNKS) send_item(completion(tracker.phase, '0));
    send_item(completion(tracker.phase, 11'h002));

    configure(64'($urandom_range(4096, 64)), 1'b1);
    run_random(120, 0, 0);
    configure('1, 1'b1);
    run_random(120, 84, 0);
    configure(rand64(), 1'b1);
    run_random(120, 0, 84);
    configure(64'($urandom_range(200, 16)), 1'b1);
    run_random(120, 7, 7);
    configure(rand64(), 1'b0);
    run_random(40, 7, 7);

    drain();
    if (tracker.mismatches == 0) begin
      $display("[nvme_chunked_io_queue_issuer] OK");
    end else begin
      $display("[nvme_chunked_io_queue_issuer] ERROR");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl
rtl/nci_pkg.sv
rtl/nci_engine.sv
rtl/nvme_chunked_io_queue_issuer.sv
rtl/nci_checker.sv
dv/testbench.sv
